// File: hw/rtl/angle_kalman_filter_macros.svh
// Assertion macros used by the angle Kalman filter top level.
`ifndef ANGLE_KALMAN_FILTER_MACROS_SVH
`define ANGLE_KALMAN_FILTER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define AKF_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("angle_kalman_filter: implication check failed");

// Next-cycle implication.
`define AKF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("angle_kalman_filter: next-cycle check failed");

`endif

// File: hw/rtl/akf_pkg.sv
// Types, constants and helpers of the angle Kalman filter.
package akf_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned DT_W   = 24;
   localparam int unsigned ADDR_W = 4;
   localparam int unsigned MA_W   = 35;  // multiplier operand a, signed
   localparam int unsigned MB_W   = 32;  // multiplier operand b, signed
   localparam int unsigned MR_W   = 45;  // rounded product, signed
   localparam int unsigned DEN_W  = 34;  // innovation variance, signed

   localparam logic [DATA_W-1:0] APN_RESET = 32'd1073742;
   localparam logic [DATA_W-1:0] BPN_RESET = 32'd3221225;
   localparam logic [DATA_W-1:0] MN_RESET  = 32'd536870912;
   localparam logic [DATA_W-1:0] COV_ONE   = 32'h4000_0000;

   localparam logic [1:0] REG_APN = 2'd0;
   localparam logic [1:0] REG_BPN = 2'd1;
   localparam logic [1:0] REG_MN  = 2'd2;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_LAUNCH,
      FSM_WAIT
   } fsm_type;

   typedef enum logic [3:0] {
      STP_RATE,
      STP_T,
      STP_PAA,
      STP_PBB,
      STP_INNOV,
      STP_K0,
      STP_K1,
      STP_ANG,
      STP_BIAS,
      STP_P10,
      STP_P11,
      STP_P01,
      STP_P00
   } step_type;

   typedef struct packed {
      logic start;
      logic scale30;
   } mul_ctl_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [47:0] v);
      logic signed [47:0] hi_lim;
      logic signed [47:0] lo_lim;
      hi_lim = 48'sh0000_7FFF_FFFF;
      lo_lim = -48'sh0000_8000_0000;
      if (v > hi_lim) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo_lim) begin
         return 32'sh8000_0000;
      end else begin
         return v[DATA_W-1:0];
      end
   endfunction

endpackage

// File: hw/rtl/akf_channels.sv
// Handshake channel interfaces of the angle Kalman filter.
interface akf_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [akf_pkg::DATA_W-1:0]     measured_angle;
   logic signed [akf_pkg::DATA_W-1:0]     measured_rate;
   logic        [akf_pkg::DT_W-1:0]       time_step;

   modport source (output valid, output measured_angle, output measured_rate,
                   output time_step, input ready);
   modport sink   (input valid, input measured_angle, input measured_rate,
                   input time_step, output ready);
endinterface

interface akf_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [akf_pkg::DATA_W-1:0]     filtered_angle;

   modport source (output valid, output filtered_angle, input ready);
   modport sink   (input valid, input filtered_angle, output ready);
endinterface

// File: hw/rtl/angle_kalman_filter.sv
// Two-state angle and gyro bias Kalman filter, top level.
//
// Input channel req_ch carries one word per IMU sample: measured_angle and
// measured_rate (signed Q16.16) and time_step (unsigned Q0.24 seconds).
// Result channel rsp_ch returns one word, the filtered angle (signed Q16.16).
// Registers on the csr_ APB port: 0x0 angle process noise, 0x4 bias process
// noise, 0x8 measurement noise, all unsigned Q2.30; write them while idle.
// Each sample runs ten products on one bit-serial multiplier, two gains on
// one bit-serial divider and the innovation step, issued in turn by a
// sequencer. A zero innovation variance skips the divider iterations.
// A new sample is taken only after the previous one has gone through.
// The result sits in an output register; a stalled receiver lets the next
// sample be accepted and processed, and its last update waits until the
// register frees up. Reset (synchronous) restores the noise registers,
// zeros angle and bias, and sets both variances to 1.0.
module angle_kalman_filter (
   input  logic                          clock,
   input  logic                          reset,
   akf_req_if.sink                       req_ch,
   akf_rsp_if.source                     rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [akf_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [akf_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [akf_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready
);

   `include "angle_kalman_filter_macros.svh"

   typedef logic signed [akf_pkg::DATA_W-1:0] s32_type;

   logic [akf_pkg::DATA_W-1:0] apn_ff, bpn_ff, mn_ff;

   akf_pkg::fsm_type  fsm_ff, fsm_in;
   akf_pkg::step_type step_ff, step_in;

   s32_type ang_ff, bias_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   s32_type meas_ff, rate_ff, y_ff, k0_ff, k1_ff;
   logic [akf_pkg::DT_W-1:0]             dt_ff;
   logic signed [32:0]                   t_ff;
   logic signed [akf_pkg::DEN_W-1:0]     s_ff;
   logic                                 rsp_valid_ff;
   s32_type                              rsp_data_ff;

   akf_pkg::mul_ctl_type                 mul_ctl;
   logic signed [akf_pkg::MA_W-1:0]      mul_a;
   logic signed [akf_pkg::MB_W-1:0]      mul_b;
   logic                                 mul_done;
   logic signed [akf_pkg::MR_W-1:0]      mul_res;
   logic                                 div_start;
   s32_type                              div_num;
   logic                                 div_done;
   s32_type                              div_quot;

   logic req_take, is_div, unit_done, last_ok, wb, innov_ld, csr_wr;
   logic signed [32:0]                   rate_diff;
   logic signed [akf_pkg::MA_W-1:0]      inner;
   logic signed [47:0]                   r48;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         apn_ff <= akf_pkg::APN_RESET;
         bpn_ff <= akf_pkg::BPN_RESET;
         mn_ff  <= akf_pkg::MN_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            akf_pkg::REG_APN: apn_ff <= csr_pwdata;
            akf_pkg::REG_BPN: bpn_ff <= csr_pwdata;
            akf_pkg::REG_MN:  mn_ff  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         akf_pkg::REG_APN: csr_prdata = apn_ff;
         akf_pkg::REG_BPN: csr_prdata = bpn_ff;
         akf_pkg::REG_MN:  csr_prdata = mn_ff;
         default:          csr_prdata = '0;
      endcase
   end

   // sequencer: next state
   always_comb begin
      fsm_in  = fsm_ff;
      step_in = step_ff;
      case (fsm_ff)
         akf_pkg::FSM_IDLE: begin
            if (req_take) begin
               fsm_in  = akf_pkg::FSM_LAUNCH;
               step_in = akf_pkg::STP_RATE;
            end
         end
         akf_pkg::FSM_LAUNCH: begin
            if (step_ff == akf_pkg::STP_INNOV) begin
               step_in = akf_pkg::step_type'(step_ff + 4'd1);
            end else begin
               fsm_in = akf_pkg::FSM_WAIT;
            end
         end
         akf_pkg::FSM_WAIT: begin
            if (wb) begin
               if (step_ff == akf_pkg::STP_P00) begin
                  fsm_in = akf_pkg::FSM_IDLE;
               end else begin
                  fsm_in  = akf_pkg::FSM_LAUNCH;
                  step_in = akf_pkg::step_type'(step_ff + 4'd1);
               end
            end
         end
         default: fsm_in = akf_pkg::FSM_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      is_div        = (step_ff == akf_pkg::STP_K0) || (step_ff == akf_pkg::STP_K1);
      unit_done     = is_div ? div_done : mul_done;
      last_ok       = (step_ff != akf_pkg::STP_P00) || !rsp_valid_ff || rsp_ch.ready;
      req_ch.ready  = (fsm_ff == akf_pkg::FSM_IDLE);
      req_take      = req_ch.valid && (fsm_ff == akf_pkg::FSM_IDLE);
      innov_ld      = (fsm_ff == akf_pkg::FSM_LAUNCH) && (step_ff == akf_pkg::STP_INNOV);
      div_start     = (fsm_ff == akf_pkg::FSM_LAUNCH) && is_div;
      mul_ctl.start = (fsm_ff == akf_pkg::FSM_LAUNCH) && !is_div
                      && (step_ff != akf_pkg::STP_INNOV);
      mul_ctl.scale30 = (step_ff inside {akf_pkg::STP_ANG, akf_pkg::STP_BIAS,
                                         akf_pkg::STP_P10, akf_pkg::STP_P11,
                                         akf_pkg::STP_P01, akf_pkg::STP_P00});
      wb            = (fsm_ff == akf_pkg::FSM_WAIT) && unit_done && last_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff  <= akf_pkg::FSM_IDLE;
         step_ff <= akf_pkg::STP_RATE;
      end else begin
         fsm_ff  <= fsm_in;
         step_ff <= step_in;
      end
   end

   // operand selection
   always_comb begin
      rate_diff = {rate_ff[31], rate_ff} - {bias_ff[31], bias_ff};
      inner     = {{2{t_ff[32]}}, t_ff} - {{3{p01_ff[31]}}, p01_ff}
                  - {{3{p10_ff[31]}}, p10_ff} + {3'b000, apn_ff};
      mul_a     = {{3{y_ff[31]}}, y_ff};
      mul_b     = k0_ff;
      case (step_ff)
         akf_pkg::STP_RATE: begin
            mul_a = {{2{rate_diff[32]}}, rate_diff};
            mul_b = {8'd0, dt_ff};
         end
         akf_pkg::STP_T: begin
            mul_a = {{3{p11_ff[31]}}, p11_ff};
            mul_b = {8'd0, dt_ff};
         end
         akf_pkg::STP_PAA: begin
            mul_a = inner;
            mul_b = {8'd0, dt_ff};
         end
         akf_pkg::STP_PBB: begin
            mul_a = {3'b000, bpn_ff};
            mul_b = {8'd0, dt_ff};
         end
         akf_pkg::STP_ANG:  mul_b = k0_ff;
         akf_pkg::STP_BIAS: mul_b = k1_ff;
         akf_pkg::STP_P10: begin
            mul_a = {{3{p00_ff[31]}}, p00_ff};
            mul_b = k1_ff;
         end
         akf_pkg::STP_P11: begin
            mul_a = {{3{p01_ff[31]}}, p01_ff};
            mul_b = k1_ff;
         end
         akf_pkg::STP_P01: begin
            mul_a = {{3{p01_ff[31]}}, p01_ff};
            mul_b = k0_ff;
         end
         akf_pkg::STP_P00: begin
            mul_a = {{3{p00_ff[31]}}, p00_ff};
            mul_b = k0_ff;
         end
         default: ;
      endcase
      div_num = (step_ff == akf_pkg::STP_K1) ? p10_ff : p00_ff;
      r48     = {{3{mul_res[akf_pkg::MR_W-1]}}, mul_res};
   end

   akf_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mul_ctl),
      .a      (mul_a),
      .b      (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   akf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (s_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         ang_ff  <= '0;
         bias_ff <= '0;
         p00_ff  <= akf_pkg::COV_ONE;
         p01_ff  <= '0;
         p10_ff  <= '0;
         p11_ff  <= akf_pkg::COV_ONE;
      end else if (wb) begin
         case (step_ff)
            akf_pkg::STP_RATE:
               ang_ff <= akf_pkg::sat32({{16{ang_ff[31]}}, ang_ff} + r48);
            akf_pkg::STP_PAA: begin
               p00_ff <= akf_pkg::sat32({{16{p00_ff[31]}}, p00_ff} + r48);
               p01_ff <= akf_pkg::sat32({{16{p01_ff[31]}}, p01_ff}
                                        - {{15{t_ff[32]}}, t_ff});
               p10_ff <= akf_pkg::sat32({{16{p10_ff[31]}}, p10_ff}
                                        - {{15{t_ff[32]}}, t_ff});
            end
            akf_pkg::STP_PBB:
               p11_ff <= akf_pkg::sat32({{16{p11_ff[31]}}, p11_ff} + r48);
            akf_pkg::STP_ANG:
               ang_ff <= akf_pkg::sat32({{16{ang_ff[31]}}, ang_ff} + r48);
            akf_pkg::STP_BIAS:
               bias_ff <= akf_pkg::sat32({{16{bias_ff[31]}}, bias_ff} + r48);
            akf_pkg::STP_P10:
               p10_ff <= akf_pkg::sat32({{16{p10_ff[31]}}, p10_ff} - r48);
            akf_pkg::STP_P11:
               p11_ff <= akf_pkg::sat32({{16{p11_ff[31]}}, p11_ff} - r48);
            akf_pkg::STP_P01:
               p01_ff <= akf_pkg::sat32({{16{p01_ff[31]}}, p01_ff} - r48);
            akf_pkg::STP_P00:
               p00_ff <= akf_pkg::sat32({{16{p00_ff[31]}}, p00_ff} - r48);
            default: ;
         endcase
      end
   end

   // sample capture and intermediate terms
   always_ff @(posedge clock) begin
      if (req_take) begin
         meas_ff <= req_ch.measured_angle;
         rate_ff <= req_ch.measured_rate;
         dt_ff   <= req_ch.time_step;
      end
      if (innov_ld) begin
         s_ff <= {{2{p00_ff[31]}}, p00_ff} + {2'b00, mn_ff};
         y_ff <= akf_pkg::sat32({{16{meas_ff[31]}}, meas_ff}
                                - {{16{ang_ff[31]}}, ang_ff});
      end
      if (wb) begin
         case (step_ff)
            akf_pkg::STP_T:  t_ff  <= mul_res[32:0];
            akf_pkg::STP_K0: k0_ff <= div_quot;
            akf_pkg::STP_K1: k1_ff <= div_quot;
            akf_pkg::STP_P00: rsp_data_ff <= ang_ff;
            default: ;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (wb && step_ff == akf_pkg::STP_P00) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.filtered_angle = rsp_data_ff;

   `AKF_ASSERT_NEXT(a_accept_starts_seq, req_ch.valid && req_ch.ready, fsm_ff == akf_pkg::FSM_LAUNCH && step_ff == akf_pkg::STP_RATE)
   `AKF_ASSERT_IMP(a_rsp_after_last_step, $rose(rsp_valid_ff), $past(fsm_ff) == akf_pkg::FSM_WAIT && $past(step_ff) == akf_pkg::STP_P00)

endmodule

// File: hw/rtl/akf_mul.sv
// Bit-serial signed multiplier with rounding right shift by 24 or 30.
module akf_mul (
   input  logic                                   clock,
   input  logic                                   reset,
   input  akf_pkg::mul_ctl_type                   ctl,
   input  logic signed [akf_pkg::MA_W-1:0]        a,
   input  logic signed [akf_pkg::MB_W-1:0]        b,
   output logic                                   done,
   output logic signed [akf_pkg::MR_W-1:0]        result
);

   localparam int unsigned PW = akf_pkg::MA_W + akf_pkg::MB_W;

   logic [akf_pkg::MA_W-1:0]   amag_ff;
   logic [akf_pkg::MA_W-1:0]   hi_ff;
   logic [akf_pkg::MB_W-1:0]   lo_ff;
   logic                       neg_ff;
   logic                       s30_ff;
   logic [4:0]                 cnt_ff;
   logic                       run_ff, run_in;
   logic                       rnd_ff, rnd_in;
   logic                       done_ff, done_in;
   logic signed [akf_pkg::MR_W-1:0] res_ff;

   logic [akf_pkg::MA_W:0]     sum;
   logic [PW-1:0]              prod;
   logic [PW-1:0]              rsum;
   logic [PW-1:0]              shifted;
   logic [akf_pkg::MR_W-1:0]   rmag;
   logic [akf_pkg::MA_W-1:0]   a_abs;
   logic [akf_pkg::MB_W-1:0]   b_abs;

   always_comb begin
      a_abs   = a[akf_pkg::MA_W-1] ? akf_pkg::MA_W'(-a) : akf_pkg::MA_W'(a);
      b_abs   = b[akf_pkg::MB_W-1] ? akf_pkg::MB_W'(-b) : akf_pkg::MB_W'(b);
      sum     = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, amag_ff} : '0);
      prod    = {hi_ff, lo_ff};
      rsum    = prod + (s30_ff ? (PW'(1) << 29) : (PW'(1) << 23));
      shifted = s30_ff ? (rsum >> 30) : (rsum >> 24);
      rmag    = shifted[akf_pkg::MR_W-1:0];
   end

   always_comb begin
      run_in = run_ff;
      if (ctl.start) begin
         run_in = 1'b1;
      end else if (run_ff && cnt_ff == 5'd31) begin
         run_in = 1'b0;
      end
      rnd_in  = run_ff && cnt_ff == 5'd31 && !ctl.start;
      done_in = ctl.start ? 1'b0 : (rnd_ff ? 1'b1 : done_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         rnd_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         rnd_ff  <= rnd_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         amag_ff <= a_abs;
         lo_ff   <= b_abs;
         hi_ff   <= '0;
         neg_ff  <= a[akf_pkg::MA_W-1] ^ b[akf_pkg::MB_W-1];
         s30_ff  <= ctl.scale30;
         cnt_ff  <= '0;
      end else if (run_ff) begin
         // add then shift the product one bit right
         hi_ff  <= sum[akf_pkg::MA_W:1];
         lo_ff  <= {sum[0], lo_ff[akf_pkg::MB_W-1:1]};
         cnt_ff <= cnt_ff + 5'd1;
      end
      if (rnd_ff) begin
         res_ff <= neg_ff ? -$signed(rmag) : $signed(rmag);
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// File: hw/rtl/akf_div.sv
// Bit-serial restoring divider forming a saturated Q2.30 gain.
module akf_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [akf_pkg::DATA_W-1:0]      num,
   input  logic signed [akf_pkg::DEN_W-1:0]       den,
   output logic                                   done,
   output logic signed [akf_pkg::DATA_W-1:0]      quot
);

   localparam int unsigned QW = akf_pkg::DATA_W + 30;

   logic [QW-1:0]               q_ff;
   logic [akf_pkg::DEN_W-1:0]   rem_ff;
   logic [akf_pkg::DEN_W-1:0]   dmag_ff;
   logic                        neg_ff;
   logic                        zero_ff;
   logic [5:0]                  cnt_ff;
   logic                        run_ff, run_in;
   logic                        fin_ff, fin_in;
   logic                        done_ff, done_in;
   logic signed [akf_pkg::DATA_W-1:0] quot_ff;

   logic [akf_pkg::DEN_W:0]     trial;
   logic                        ge;
   logic [akf_pkg::DEN_W:0]     diff;
   logic [akf_pkg::DATA_W-1:0]  n_abs;
   logic [akf_pkg::DEN_W-1:0]   d_abs;
   logic                        den_zero;
   logic                        pos_ovf;
   logic                        neg_ovf;

   always_comb begin
      n_abs    = num[akf_pkg::DATA_W-1] ? akf_pkg::DATA_W'(-num) : akf_pkg::DATA_W'(num);
      d_abs    = den[akf_pkg::DEN_W-1] ? akf_pkg::DEN_W'(-den) : akf_pkg::DEN_W'(den);
      den_zero = (den == '0);
      trial    = {rem_ff, q_ff[QW-1]};
      ge       = trial >= {1'b0, dmag_ff};
      diff     = trial - {1'b0, dmag_ff};
      pos_ovf  = |q_ff[QW-1:31];
      neg_ovf  = (|q_ff[QW-1:32]) || (q_ff[31] && (|q_ff[30:0]));
   end

   always_comb begin
      run_in = run_ff;
      if (start) begin
         run_in = !den_zero;
      end else if (run_ff && cnt_ff == 6'(QW - 1)) begin
         run_in = 1'b0;
      end
      fin_in  = start ? den_zero : (run_ff && cnt_ff == 6'(QW - 1));
      done_in = start ? 1'b0 : (fin_ff ? 1'b1 : done_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff    <= {n_abs, 30'd0};
         rem_ff  <= '0;
         dmag_ff <= d_abs;
         neg_ff  <= num[akf_pkg::DATA_W-1] ^ den[akf_pkg::DEN_W-1];
         zero_ff <= den_zero;
         cnt_ff  <= '0;
      end else if (run_ff) begin
         // one quotient bit per cycle
         rem_ff <= ge ? diff[akf_pkg::DEN_W-1:0] : trial[akf_pkg::DEN_W-1:0];
         q_ff   <= {q_ff[QW-2:0], ge};
         cnt_ff <= cnt_ff + 6'd1;
      end
      if (fin_ff) begin
         if (zero_ff) begin
            quot_ff <= '0;
         end else if (!neg_ff) begin
            quot_ff <= pos_ovf ? 32'sh7FFF_FFFF : $signed(q_ff[akf_pkg::DATA_W-1:0]);
         end else begin
            quot_ff <= neg_ovf ? 32'sh8000_0000 : -$signed(q_ff[akf_pkg::DATA_W-1:0]);
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
